>>> hw/rtl/nssc_pkg.sv
package nssc_pkg;

	// Configuration port
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 13;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SOURCE_WIDTH  = 8'd0,
		REG_SOURCE_HEIGHT = 8'd1,
		REG_CELLS_ACROSS  = 8'd2,
		REG_CELLS_DOWN    = 8'd3
	} cfg_reg_t;

	// Register widths and reset values
	localparam int SIDE_CFG_W         = 13;
	localparam int CELLS_ACROSS_CFG_W = 9;
	localparam int CELLS_DOWN_CFG_W   = 8;

	localparam logic [SIDE_CFG_W-1:0]         RST_SOURCE_WIDTH  = 13'd320;
	localparam logic [SIDE_CFG_W-1:0]         RST_SOURCE_HEIGHT = 13'd240;
	localparam logic [CELLS_ACROSS_CFG_W-1:0] RST_CELLS_ACROSS  = 9'd80;
	localparam logic [CELLS_DOWN_CFG_W-1:0]   RST_CELLS_DOWN    = 8'd40;

	// Parameter defaults
	localparam int DEF_MAX_CELLS_ACROSS = 300;
	localparam int DEF_MAX_CELLS_DOWN   = 150;
	localparam int DEF_MAX_SOURCE_SIDE  = 4096;

	// Payload widths
	localparam int COLOR_W       = 8;
	localparam int CELL_COLUMN_W = 9;
	localparam int CELL_ROW_W    = 8;
	localparam int SHADE_W       = 3;

	// Q16 luma weights, summing to 65536
	localparam int LUMA_W = 24;
	localparam logic [LUMA_W-1:0] LUMA_WEIGHT_RED   = 24'd19595;
	localparam logic [LUMA_W-1:0] LUMA_WEIGHT_GREEN = 24'd38470;
	localparam logic [LUMA_W-1:0] LUMA_WEIGHT_BLUE  = 24'd7471;
	// One shade step in luma units: 255 * 65536 / 4
	localparam int SHADE_STEP = 255 * 16384;

	typedef struct packed {
		logic                     hit;
		logic [CELL_COLUMN_W-1:0] column;
		logic [CELL_ROW_W-1:0]    row;
		logic                     last;
	} sample_t;

endpackage

>>> hw/rtl/nssc_shade.sv
module nssc_shade
	import nssc_pkg::*;
(
	input  logic [COLOR_W-1:0] red,
	input  logic [COLOR_W-1:0] green,
	input  logic [COLOR_W-1:0] blue,
	output logic [SHADE_W-1:0] level
);

	localparam logic [LUMA_W-1:0] STEP1 = LUMA_W'(SHADE_STEP);
	localparam logic [LUMA_W-1:0] STEP2 = LUMA_W'(2 * SHADE_STEP);
	localparam logic [LUMA_W-1:0] STEP3 = LUMA_W'(3 * SHADE_STEP);
	localparam logic [LUMA_W-1:0] STEP4 = LUMA_W'(4 * SHADE_STEP);

	logic [LUMA_W-1:0] luma;

	// weights sum to 2^16, so the full-scale luma fits exactly
	assign luma = LUMA_W'(red) * LUMA_WEIGHT_RED
		+ LUMA_W'(green) * LUMA_WEIGHT_GREEN
		+ LUMA_W'(blue) * LUMA_WEIGHT_BLUE;

	always_comb begin
		priority if (luma >= STEP4) begin
			level = SHADE_W'(4);
		end else if (luma >= STEP3) begin
			level = SHADE_W'(3);
		end else if (luma >= STEP2) begin
			level = SHADE_W'(2);
		end else if (luma >= STEP1) begin
			level = SHADE_W'(1);
		end else begin
			level = SHADE_W'(0);
		end
	end

endmodule

>>> hw/rtl/nssc_sampler.sv
module nssc_sampler
	import nssc_pkg::*;
#(
	parameter int MAX_CELLS_ACROSS = DEF_MAX_CELLS_ACROSS,
	parameter int MAX_CELLS_DOWN   = DEF_MAX_CELLS_DOWN,
	parameter int MAX_SOURCE_SIDE  = DEF_MAX_SOURCE_SIDE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          frame_start,
	input  logic [SIDE_CFG_W-1:0]         source_width,
	input  logic [SIDE_CFG_W-1:0]         source_height,
	input  logic [CELLS_ACROSS_CFG_W-1:0] cells_across,
	input  logic [CELLS_DOWN_CFG_W-1:0]   cells_down,
	output sample_t                       sample
);

	localparam int SIDE_W    = $clog2(MAX_SOURCE_SIDE + 1);
	localparam int POS_W     = $clog2(MAX_SOURCE_SIDE) + 1;
	localparam int COL_W     = $clog2(MAX_CELLS_ACROSS + 1);
	localparam int ROW_W     = $clog2(MAX_CELLS_DOWN + 1);
	localparam int COL_SUM_W = $clog2(MAX_CELLS_ACROSS * MAX_SOURCE_SIDE + MAX_CELLS_ACROSS + 1);
	localparam int ROW_SUM_W = $clog2(MAX_CELLS_DOWN * MAX_SOURCE_SIDE + MAX_CELLS_DOWN + 1);

	logic [SIDE_W-1:0] w, h;
	logic [COL_W-1:0]  cw_lim, cw;
	logic [ROW_W-1:0]  ch_lim, ch;

	logic [POS_W-2:0]     src_col_q, src_row_q, src_col_c, src_row_c, src_col_d, src_row_d;
	logic [COL_W-1:0]     ncc_q, ncc_c, ncc_d;
	logic [ROW_W-1:0]     ncr_q, ncr_c, ncr_d;
	logic [COL_SUM_W-1:0] col_tgt_q, col_win_q, col_tgt_c, col_win_c, col_tgt_d, col_win_d;
	logic [ROW_SUM_W-1:0] row_tgt_q, row_win_q, row_tgt_c, row_win_c, row_tgt_d, row_win_d;

	logic [POS_W-1:0] src_col_inc, src_row_inc;
	logic             col_hit, row_hit, row_end, frame_end;

	// Effective sizes: zero reads as one, sizes saturate at their maximum, cell counts are capped at the source size
	always_comb begin
		if (source_width == '0) begin
			w = SIDE_W'(1);
		end else if (32'(source_width) > MAX_SOURCE_SIDE) begin
			w = SIDE_W'(MAX_SOURCE_SIDE);
		end else begin
			w = SIDE_W'(source_width);
		end
		if (source_height == '0) begin
			h = SIDE_W'(1);
		end else if (32'(source_height) > MAX_SOURCE_SIDE) begin
			h = SIDE_W'(MAX_SOURCE_SIDE);
		end else begin
			h = SIDE_W'(source_height);
		end
		if (cells_across == '0) begin
			cw_lim = COL_W'(1);
		end else if (32'(cells_across) > MAX_CELLS_ACROSS) begin
			cw_lim = COL_W'(MAX_CELLS_ACROSS);
		end else begin
			cw_lim = COL_W'(cells_across);
		end
		if (cells_down == '0) begin
			ch_lim = ROW_W'(1);
		end else if (32'(cells_down) > MAX_CELLS_DOWN) begin
			ch_lim = ROW_W'(MAX_CELLS_DOWN);
		end else begin
			ch_lim = ROW_W'(cells_down);
		end
		cw = (32'(cw_lim) > 32'(w)) ? COL_W'(w) : cw_lim;
		ch = (32'(ch_lim) > 32'(h)) ? ROW_W'(h) : ch_lim;
	end

	// frame_start clears every counter ahead of this pixel
	assign src_col_c = frame_start ? '0 : src_col_q;
	assign src_row_c = frame_start ? '0 : src_row_q;
	assign ncc_c     = frame_start ? '0 : ncc_q;
	assign ncr_c     = frame_start ? '0 : ncr_q;
	assign col_tgt_c = frame_start ? '0 : col_tgt_q;
	assign col_win_c = frame_start ? '0 : col_win_q;
	assign row_tgt_c = frame_start ? '0 : row_tgt_q;
	assign row_win_c = frame_start ? '0 : row_win_q;

	assign col_hit = (ncc_c < cw) && (col_tgt_c < col_win_c + COL_SUM_W'(cw));
	assign row_hit = (ncr_c < ch) && (row_tgt_c < row_win_c + ROW_SUM_W'(ch));

	assign src_col_inc = {1'b0, src_col_c} + POS_W'(1);
	assign src_row_inc = {1'b0, src_row_c} + POS_W'(1);
	assign row_end     = src_col_inc >= POS_W'(w);
	assign frame_end   = src_row_inc >= POS_W'(h);

	always_comb begin
		sample.hit    = col_hit && row_hit;
		sample.column = CELL_COLUMN_W'(ncc_c);
		sample.row    = CELL_ROW_W'(ncr_c);
		sample.last   = ({1'b0, ncc_c} + (COL_W + 1)'(1) == {1'b0, cw})
			&& ({1'b0, ncr_c} + (ROW_W + 1)'(1) == {1'b0, ch});
	end

	always_comb begin
		src_col_d = src_col_c;
		src_row_d = src_row_c;
		ncc_d     = ncc_c;
		ncr_d     = ncr_c;
		col_tgt_d = col_tgt_c;
		col_win_d = col_win_c;
		row_tgt_d = row_tgt_c;
		row_win_d = row_win_c;
		if (col_hit) begin
			ncc_d     = ncc_c + COL_W'(1);
			col_tgt_d = col_tgt_c + COL_SUM_W'(w);
		end
		if (row_end) begin
			src_col_d = '0;
			col_win_d = '0;
			ncc_d     = '0;
			col_tgt_d = '0;
			if (row_hit) begin
				ncr_d     = ncr_c + ROW_W'(1);
				row_tgt_d = row_tgt_c + ROW_SUM_W'(h);
			end
			if (frame_end) begin
				src_row_d = '0;
				row_win_d = '0;
				ncr_d     = '0;
				row_tgt_d = '0;
			end else begin
				src_row_d = src_row_inc[POS_W-2:0];
				row_win_d = row_win_c + ROW_SUM_W'(ch);
			end
		end else begin
			src_col_d = src_col_inc[POS_W-2:0];
			col_win_d = col_win_c + COL_SUM_W'(cw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			ncc_q     <= '0;
			ncr_q     <= '0;
			col_tgt_q <= '0;
			col_win_q <= '0;
			row_tgt_q <= '0;
			row_win_q <= '0;
		end else if (advance) begin
			src_col_q <= src_col_d;
			src_row_q <= src_row_d;
			ncc_q     <= ncc_d;
			ncr_q     <= ncr_d;
			col_tgt_q <= col_tgt_d;
			col_win_q <= col_win_d;
			row_tgt_q <= row_tgt_d;
			row_win_q <= row_win_d;
		end
	end

endmodule

>>> hw/rtl/nearest_sample_shade_cells_unit.sv
// Nearest-sample shade cells.
// Source RGB pixels enter in raster order on the input channel (in_valid,
// in_stall); frame_start marks the top-left pixel and clears all counters.
// Each pixel that a display cell samples leaves on the output channel
// (out_valid, out_stall) with the cell position, its RGB, a shade level
// 0..4 and last_cell on the final cell of the frame. Pixels that no cell
// samples are consumed without a transfer on the output side.
// A pixel that is taken is registered in the input stage; its result is
// then loaded into the output register and offered from there.
// Throughput: one pixel per cycle while the output is not stalled; the
// sampling counters and the luma compare close within a single stage.
// When the receiver stalls, the output register holds its result and the
// input stage keeps moving until it holds a pixel that cannot advance;
// then in_stall rises until the output register is taken.
// Configuration writes (cfg_valid, cfg_ready) are always taken; write them
// only between frames or with no pixel in flight. Reset loads the default
// sizes (320x240 source, 80x40 cells), clears the counters and empties
// both stages.
module nearest_sample_shade_cells_unit
	import nssc_pkg::*;
#(
	parameter int MAX_CELLS_ACROSS = DEF_MAX_CELLS_ACROSS,
	parameter int MAX_CELLS_DOWN   = DEF_MAX_CELLS_DOWN,
	parameter int MAX_SOURCE_SIDE  = DEF_MAX_SOURCE_SIDE
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [COLOR_W-1:0]       red_in,
	input  logic [COLOR_W-1:0]       green_in,
	input  logic [COLOR_W-1:0]       blue_in,
	input  logic                     frame_start,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CELL_COLUMN_W-1:0] cell_column,
	output logic [CELL_ROW_W-1:0]    cell_row,
	output logic [SHADE_W-1:0]       shade_level,
	output logic [COLOR_W-1:0]       red_out,
	output logic [COLOR_W-1:0]       green_out,
	output logic [COLOR_W-1:0]       blue_out,
	output logic                     last_cell
);

	logic [SIDE_CFG_W-1:0]         source_width_q, source_height_q;
	logic [CELLS_ACROSS_CFG_W-1:0] cells_across_q;
	logic [CELLS_DOWN_CFG_W-1:0]   cells_down_q;

	logic               valid_s1, frame_start_s1;
	logic [COLOR_W-1:0] red_s1, green_s1, blue_s1;

	logic               out_valid_q, last_cell_q;
	logic [CELL_COLUMN_W-1:0] cell_column_q;
	logic [CELL_ROW_W-1:0]    cell_row_q;
	logic [SHADE_W-1:0]       shade_q, shade;
	logic [COLOR_W-1:0]       red_q, green_q, blue_q;

	sample_t sample;
	logic    out_free, advance_s1, load_s1;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= RST_SOURCE_WIDTH;
			source_height_q <= RST_SOURCE_HEIGHT;
			cells_across_q  <= RST_CELLS_ACROSS;
			cells_down_q    <= RST_CELLS_DOWN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH:  source_width_q  <= cfg_data[SIDE_CFG_W-1:0];
				REG_SOURCE_HEIGHT: source_height_q <= cfg_data[SIDE_CFG_W-1:0];
				REG_CELLS_ACROSS:  cells_across_q  <= cfg_data[CELLS_ACROSS_CFG_W-1:0];
				REG_CELLS_DOWN:    cells_down_q    <= cfg_data[CELLS_DOWN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 advances whenever the output register is empty or being taken
	assign out_free   = !out_valid_q || !out_stall;
	assign advance_s1 = valid_s1 && out_free;
	assign load_s1    = !valid_s1 || advance_s1;
	assign in_stall   = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && load_s1) begin
			red_s1         <= red_in;
			green_s1       <= green_in;
			blue_s1        <= blue_in;
			frame_start_s1 <= frame_start;
		end
	end

	nssc_sampler #(
		.MAX_CELLS_ACROSS (MAX_CELLS_ACROSS),
		.MAX_CELLS_DOWN   (MAX_CELLS_DOWN),
		.MAX_SOURCE_SIDE  (MAX_SOURCE_SIDE)
	) u_sampler (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance_s1),
		.frame_start   (frame_start_s1),
		.source_width  (source_width_q),
		.source_height (source_height_q),
		.cells_across  (cells_across_q),
		.cells_down    (cells_down_q),
		.sample        (sample)
	);

	nssc_shade u_shade (
		.red   (red_s1),
		.green (green_s1),
		.blue  (blue_s1),
		.level (shade)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance_s1 && sample.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && sample.hit) begin
			cell_column_q <= sample.column;
			cell_row_q    <= sample.row;
			last_cell_q   <= sample.last;
			shade_q       <= shade;
			red_q         <= red_s1;
			green_q       <= green_s1;
			blue_q        <= blue_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign cell_column = cell_column_q;
	assign cell_row    = cell_row_q;
	assign shade_level = shade_q;
	assign red_out     = red_q;
	assign green_out   = green_q;
	assign blue_out    = blue_q;
	assign last_cell   = last_cell_q;

endmodule
